### design/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, codes and constants of the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int QUERY_DEPTH_DEF = 32;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_CHAR   = 2'd2;
    localparam logic [1:0] FUNC_EMPTY  = 2'd3;

    localparam logic [7:0]  SCORE_MATCH = 8'd10;
    localparam logic [7:0]  SCORE_START = 8'd15;
    localparam logic [4:0]  RUN_MAX     = 5'd31;
    localparam logic [12:0] ACCUM_MAX   = 13'd8191;
    localparam logic [15:0] LEN_MAX     = 16'hFFFF;

    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_DASH  = 16'h002D;
    localparam logic [15:0] CH_UNDER = 16'h005F;
    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_UC_A  = 16'h0041;
    localparam logic [15:0] CH_UC_Z  = 16'h005A;
    localparam logic [15:0] CH_FOLD  = 16'h0020;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] ch;
        logic        last;
    } t_in;

    typedef struct packed {
        logic signed [16:0] match_score;
        logic               matched;
        logic [15:0]        candidate_index;
    } t_out;

    function automatic logic [15:0] fold(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            r = c + CH_FOLD;
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [15:0] c);
        return (c == CH_SPACE) || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_SLASH);
    endfunction

endpackage

### design/fss_qmem.sv
// ----------------------------------------------------------------------------
// fss_qmem
// Query character store: one write port, one registered read port with
// write-to-read forwarding on the same address.
// ----------------------------------------------------------------------------
module fss_qmem #(
    parameter int QUERY_DEPTH = fss_pkg::QUERY_DEPTH_DEF,
    parameter int AW          = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [QUERY_DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/fss_core.sv
// ----------------------------------------------------------------------------
// fss_core
// Per-beat match and score update; prefetches the next query character.
// ----------------------------------------------------------------------------
module fss_core #(
    parameter int QUERY_DEPTH = fss_pkg::QUERY_DEPTH_DEF,
    parameter int LW          = $clog2(QUERY_DEPTH + 1),
    parameter int AW          = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  fss_pkg::t_in   i_data,
    output logic           o_we,
    output logic [AW-1:0]  o_waddr,
    output logic [15:0]    o_wdata,
    output logic [AW-1:0]  o_raddr,
    input  logic [15:0]    i_qchar,
    output logic           o_res_valid,
    output fss_pkg::t_out  o_res
);

    logic [LW-1:0] r_qlen, n_qlen;
    logic [LW-1:0] r_pos, n_pos;
    logic [4:0]    r_run, n_run;
    logic          r_prev_m, n_prev_m;
    logic          r_prev_sep, n_prev_sep;
    logic [15:0]   r_clen, n_clen;
    logic [12:0]   r_accum, n_accum;
    logic [15:0]   r_count, n_count;

    logic [LW-1:0] t_pos;
    logic [4:0]    t_run;
    logic          t_prev_m;
    logic [15:0]   t_clen;
    logic [12:0]   t_accum;
    logic [7:0]    t_add;
    logic [13:0]   t_sum;
    logic [17:0]   t_score;
    logic          t_emit;
    logic          t_hit;

    always_comb begin
        n_qlen     = r_qlen;
        n_pos      = r_pos;
        n_run      = r_run;
        n_prev_m   = r_prev_m;
        n_prev_sep = r_prev_sep;
        n_clen     = r_clen;
        n_accum    = r_accum;
        n_count    = r_count;
        o_we       = 1'b0;
        o_waddr    = r_qlen[AW-1:0];
        o_wdata    = fss_pkg::fold(i_data.ch);
        t_emit     = 1'b0;
        t_pos      = r_pos;
        t_run      = r_run;
        t_prev_m   = r_prev_m;
        t_clen     = r_clen;
        t_accum    = r_accum;
        t_add      = 8'd0;
        t_sum      = 14'd0;
        t_hit      = 1'b0;

        if (i_take) begin
            unique case (i_data.func)
                fss_pkg::FUNC_CLEAR: begin
                    n_qlen  = '0;
                    n_count = '0;
                end
                fss_pkg::FUNC_APPEND: begin
                    if (r_qlen < LW'(QUERY_DEPTH)) begin
                        o_we   = 1'b1;
                        n_qlen = r_qlen + LW'(1);
                    end
                end
                fss_pkg::FUNC_CHAR: begin
                    if (r_pos < r_qlen) begin
                        t_hit = (fss_pkg::fold(i_data.ch) == i_qchar);
                        if (t_hit) begin
                            if (r_prev_m) begin
                                t_run = (r_run < fss_pkg::RUN_MAX) ? r_run + 5'd1 : r_run;
                                t_add = fss_pkg::SCORE_MATCH + 8'({t_run, 2'b00}) + 8'(t_run);
                            end else begin
                                t_run = 5'd0;
                                t_add = fss_pkg::SCORE_MATCH;
                            end
                            if (r_clen == 16'd0 || r_prev_sep) begin
                                t_add = t_add + fss_pkg::SCORE_START;
                            end
                            t_sum    = 14'(r_accum) + 14'(t_add);
                            t_accum  = (t_sum > 14'(fss_pkg::ACCUM_MAX)) ?
                                       fss_pkg::ACCUM_MAX : t_sum[12:0];
                            t_prev_m = 1'b1;
                            t_pos    = r_pos + LW'(1);
                        end else begin
                            t_prev_m = 1'b0;
                            t_run    = 5'd0;
                        end
                    end
                    t_clen     = (r_clen < fss_pkg::LEN_MAX) ? r_clen + 16'd1 : r_clen;
                    n_pos      = t_pos;
                    n_run      = t_run;
                    n_prev_m   = t_prev_m;
                    n_prev_sep = fss_pkg::is_sep(i_data.ch);
                    n_clen     = t_clen;
                    n_accum    = t_accum;
                    t_emit     = i_data.last;
                end
                fss_pkg::FUNC_EMPTY: begin
                    t_pos   = '0;
                    t_clen  = 16'd0;
                    t_accum = 13'd0;
                    t_emit  = 1'b1;
                end
                default: begin
                end
            endcase

            if (i_data.func != fss_pkg::FUNC_CHAR || t_emit) begin
                n_pos      = '0;
                n_run      = 5'd0;
                n_prev_m   = 1'b0;
                n_prev_sep = 1'b0;
                n_clen     = 16'd0;
                n_accum    = 13'd0;
            end
            if (t_emit && r_count < fss_pkg::LEN_MAX) begin
                n_count = r_count + 16'd1;
            end
        end
    end

    assign o_raddr = n_pos[AW-1:0];

    always_comb begin
        t_score = 18'(t_accum) - 18'(t_clen) + 18'(r_qlen);
        o_res_valid           = t_emit;
        o_res.candidate_index = r_count;
        if (r_qlen == '0) begin
            o_res.match_score = 17'sd0;
            o_res.matched     = 1'b1;
        end else if (t_pos < r_qlen) begin
            o_res.match_score = -17'sd1;
            o_res.matched     = 1'b0;
        end else begin
            o_res.match_score = $signed(t_score[16:0]);
            o_res.matched     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen     <= '0;
            r_pos      <= '0;
            r_run      <= 5'd0;
            r_prev_m   <= 1'b0;
            r_prev_sep <= 1'b0;
            r_clen     <= 16'd0;
            r_accum    <= 13'd0;
            r_count    <= 16'd0;
        end else begin
            r_qlen     <= n_qlen;
            r_pos      <= n_pos;
            r_run      <= n_run;
            r_prev_m   <= n_prev_m;
            r_prev_sep <= n_prev_sep;
            r_clen     <= n_clen;
            r_accum    <= n_accum;
            r_count    <= n_count;
        end
    end

endmodule

### design/fss_outbuf.sv
// ----------------------------------------------------------------------------
// fss_outbuf
// Output register with one skid entry; ready toward the core is registered.
// ----------------------------------------------------------------------------
module fss_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_valid,
    input  fss_pkg::t_out i_res,
    output logic          o_space,
    output logic          o_valid,
    input  logic          i_ready,
    output fss_pkg::t_out o_data
);

    logic          r_out_v, r_skid_v;
    fss_pkg::t_out r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !i_ready) begin
            if (i_res_valid) begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_ready) begin
            if (i_res_valid) begin
                r_skid <= i_res;
            end
        end else if (r_skid_v) begin
            r_out <= r_skid;
        end else if (i_res_valid) begin
            r_out <= i_res;
        end
    end

    assign o_space = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

### design/fuzzy_subsequence_scorer.sv
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Streams a query and candidate strings; emits one score per candidate.
//
// Input channel (i_valid/o_ready, i_data): one beat per command or character.
// Clear and append load the query into the query store; candidate beats are
// matched greedily against the next query character, case-folded on A-Z.
// Output channel (o_valid/i_ready, o_data): one beat per candidate, after its
// last character or an empty-candidate command; other beats give none.
// Throughput: one input beat per cycle while o_ready is high. The next query
// character is read ahead from the store at the next match position, so a
// match on one beat feeds the read address for the following beat.
// Output: each result is registered in the output buffer before o_data.
// Stall: an output register plus one skid entry; when both are full o_ready
// drops until the receiver takes a beat.
// Reset: synchronous, active low; empties the query, the candidate state,
// the counter and the output buffer. The store needs no clearing.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer #(
    parameter int QUERY_DEPTH = fss_pkg::QUERY_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fss_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output fss_pkg::t_out o_data
);

    localparam int LW = $clog2(QUERY_DEPTH + 1);
    localparam int AW = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;

    logic          w_take;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata, w_qchar;
    logic          w_res_valid;
    fss_pkg::t_out w_res;
    logic          w_space;

    assign o_ready = w_space;
    assign w_take  = i_valid && w_space;

    fss_qmem #(
        .QUERY_DEPTH (QUERY_DEPTH),
        .AW          (AW)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_qchar)
    );

    fss_core #(
        .QUERY_DEPTH (QUERY_DEPTH),
        .LW          (LW),
        .AW          (AW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_data      (i_data),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_qchar     (w_qchar),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    fss_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_space     (w_space),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
